// File: design/ett_pkg.sv
// Package for the eased transition tween: shared codes, command and status types.
// Used by ett_ctrl, ett_dp and eased_transition_tween_core; depends on nothing.
package ett_pkg;

    // Command opcodes carried by an input word.
    localparam logic [2:0] OP_TICK        = 3'd0;
    localparam logic [2:0] OP_PLAY_FWD    = 3'd1;
    localparam logic [2:0] OP_PLAY_BACK   = 3'd2;
    localparam logic [2:0] OP_JUMP_HIDDEN = 3'd3;
    localparam logic [2:0] OP_JUMP_SHOWN  = 3'd4;

    // Easing curve codes.
    localparam logic [2:0] EASE_LINEAR   = 3'd0;
    localparam logic [2:0] EASE_IN_QUAD  = 3'd1;
    localparam logic [2:0] EASE_OUT_QUAD = 3'd2;
    localparam logic [2:0] EASE_IN_OUT   = 3'd3;
    localparam logic [2:0] EASE_OUT_BACK = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_HIDDEN_TR    = 3'd0;
    localparam logic [2:0] REG_HIDDEN_SCALE = 3'd1;
    localparam logic [2:0] REG_HIDDEN_ALPHA = 3'd2;
    localparam logic [2:0] REG_SHOWN_TR     = 3'd3;
    localparam logic [2:0] REG_SHOWN_SCALE  = 3'd4;
    localparam logic [2:0] REG_SHOWN_ALPHA  = 3'd5;
    localparam logic [2:0] REG_DURATION     = 3'd6;
    localparam logic [2:0] REG_EASING       = 3'd7;

    // Register reset values.
    localparam logic [31:0] SCALE_RESET = 32'h0100_0100;
    localparam logic [7:0]  SHOWN_ALPHA_RESET = 8'hFF;

    // Interpolated channels, in processing order.
    localparam logic [2:0] CH_POS_X   = 3'd0;
    localparam logic [2:0] CH_POS_Y   = 3'd1;
    localparam logic [2:0] CH_SCALE_X = 3'd2;
    localparam logic [2:0] CH_SCALE_Y = 3'd3;
    localparam logic [2:0] CH_ALPHA   = 3'd4;
    localparam logic [2:0] CH_LAST    = CH_ALPHA;

    // Datapath operations.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_ELAPSED,
        DP_PLAY,
        DP_JUMP,
        DP_FINISH,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_SETU,
        DP_E_FROM_T,
        DP_E_FROM_M,
        DP_E_ONE_MINUS_M,
        DP_U2_FROM_M,
        DP_U3_FROM_M,
        DP_ACC_FROM_M,
        DP_E_OUTBACK,
        DP_LERP_LOAD
    } dp_op_t;

    // Multiplier operand sources.
    typedef enum logic [2:0] {
        SRC_T,
        SRC_U,
        SRC_U2,
        SRC_U3,
        SRC_C1,
        SRC_C1P,
        SRC_DIFF,
        SRC_E
    } mul_src_t;

    // Product scaling: shift right by FRAC_BITS-1, FRAC_BITS or FRAC_BITS+1.
    typedef enum logic [1:0] {
        SH_FM1,
        SH_F,
        SH_FP1
    } shift_t;

    // Controller to datapath command.
    typedef struct packed {
        dp_op_t     op;
        logic       lerp_store;
        mul_src_t   src_a;
        mul_src_t   src_b;
        shift_t     shift;
        logic       mul_load;
        logic [2:0] ch;
        logic       dir;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic       running;
        logic       done;
        logic       t_half;
        logic [2:0] mode;
    } status_t;

endpackage

// File: design/eased_transition_tween_core.sv
// Eased transition tween, top level: joins the controller and the datapath.
// Depends on ett_pkg, ett_ctrl and ett_dp.
//
// One command word in, one pose word out. Play, jump and ignored commands, and
// a tick while stopped, present their result straight after the decode state; a
// tick that completes the transition passes the completion check first. A running
// tick runs a bit-serial divider for the progress, then the easing multiplies (none
// for linear, one for the quadratic curves, four for out-back) and one multiply per
// channel for the five channels in turn, all on one shared, two-stage multiplier.
// A new word can be taken in the cycle after the previous result has been delivered.
// Configuration writes are always ready and must be made while the block is idle.
module eased_transition_tween_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         opcode,
    input  logic [15:0]        delta_ticks,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [23:0] pos_x,
    output logic signed [23:0] pos_y,
    output logic [15:0]        scale_x,
    output logic [15:0]        scale_y,
    output logic [7:0]         alpha_out,
    output logic               playing,
    output logic               heading_shown
);

    ett_pkg::cmd_t    cmd;
    ett_pkg::status_t status;
    logic             in_accept;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid & ~in_stall;

    // Sequencer.
    ett_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and state.
    ett_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_accept     (in_accept),
        .delta_ticks   (delta_ticks),
        .cmd           (cmd),
        .status        (status),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .scale_x       (scale_x),
        .scale_y       (scale_y),
        .alpha_out     (alpha_out),
        .playing       (playing),
        .heading_shown (heading_shown)
    );

endmodule

// File: design/ett_ctrl.sv
// Controller state machine of the eased transition tween.
// Depends on ett_pkg; drives ett_dp through cmd_t and reads status_t.
module ett_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        opcode,
    output logic              out_valid,
    input  logic              out_stall,
    input  ett_pkg::status_t  status,
    output ett_pkg::cmd_t     cmd
);

    localparam int CW = $clog2(FRAC_BITS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_DIV,
        S_EASE0,
        S_EASE1,
        S_MLOAD,
        S_MW1,
        S_MW2,
        S_MUSE,
        S_LERP_LOAD,
        S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  op_reg, op_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]  jstep_reg, jstep_next;
    logic [2:0]  ch_reg, ch_next;
    logic        lerp_reg, lerp_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        jstep_next = jstep_reg;
        ch_next    = ch_reg;
        lerp_next  = lerp_reg;
        cmd.op         = ett_pkg::DP_NOP;
        cmd.lerp_store = 1'b0;
        cmd.src_a      = ett_pkg::SRC_T;
        cmd.src_b      = ett_pkg::SRC_T;
        cmd.shift      = ett_pkg::SH_F;
        cmd.mul_load   = 1'b0;
        cmd.ch         = ch_reg;
        cmd.dir        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_OUT;
                case (op_reg)
                    ett_pkg::OP_TICK:
                    begin
                        if (status.running)
                        begin
                            cmd.op     = ett_pkg::DP_ELAPSED;
                            state_next = S_CHECK;
                        end
                    end
                    ett_pkg::OP_PLAY_FWD:
                    begin
                        cmd.op  = ett_pkg::DP_PLAY;
                        cmd.dir = 1'b1;
                    end
                    ett_pkg::OP_PLAY_BACK:
                    begin
                        cmd.op  = ett_pkg::DP_PLAY;
                        cmd.dir = 1'b0;
                    end
                    ett_pkg::OP_JUMP_HIDDEN:
                    begin
                        cmd.op  = ett_pkg::DP_JUMP;
                        cmd.dir = 1'b0;
                    end
                    ett_pkg::OP_JUMP_SHOWN:
                    begin
                        cmd.op  = ett_pkg::DP_JUMP;
                        cmd.dir = 1'b1;
                    end
                    default:
                    begin
                        cmd.op = ett_pkg::DP_NOP;
                    end
                endcase
            end
            S_CHECK:
            begin
                if (status.done)
                begin
                    cmd.op     = ett_pkg::DP_FINISH;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.op     = ett_pkg::DP_DIV_INIT;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op = ett_pkg::DP_DIV_STEP;
                if (cnt_reg == CW'(FRAC_BITS - 1))
                begin
                    state_next = S_EASE0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_EASE0:
            begin
                cmd.op     = ett_pkg::DP_SETU;
                state_next = S_EASE1;
            end
            S_EASE1:
            begin
                jstep_next = '0;
                lerp_next  = 1'b0;
                case (status.mode)
                    ett_pkg::EASE_IN_QUAD, ett_pkg::EASE_OUT_QUAD,
                    ett_pkg::EASE_IN_OUT, ett_pkg::EASE_OUT_BACK:
                    begin
                        state_next = S_MLOAD;
                    end
                    default:
                    begin
                        cmd.op     = ett_pkg::DP_E_FROM_T;
                        ch_next    = ett_pkg::CH_POS_X;
                        state_next = S_LERP_LOAD;
                    end
                endcase
            end
            S_MLOAD:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_MW1;
                if (lerp_reg)
                begin
                    cmd.src_a = ett_pkg::SRC_DIFF;
                    cmd.src_b = ett_pkg::SRC_E;
                end
                else
                begin
                    case (status.mode)
                        ett_pkg::EASE_OUT_QUAD:
                        begin
                            cmd.src_a = ett_pkg::SRC_U;
                            cmd.src_b = ett_pkg::SRC_U;
                        end
                        ett_pkg::EASE_IN_OUT:
                        begin
                            if (status.t_half)
                            begin
                                cmd.shift = ett_pkg::SH_FM1;
                            end
                            else
                            begin
                                cmd.src_a = ett_pkg::SRC_U;
                                cmd.src_b = ett_pkg::SRC_U;
                                cmd.shift = ett_pkg::SH_FP1;
                            end
                        end
                        ett_pkg::EASE_OUT_BACK:
                        begin
                            case (jstep_reg)
                                2'd0:
                                begin
                                    cmd.src_a = ett_pkg::SRC_U;
                                    cmd.src_b = ett_pkg::SRC_U;
                                end
                                2'd1:
                                begin
                                    cmd.src_a = ett_pkg::SRC_U2;
                                    cmd.src_b = ett_pkg::SRC_U;
                                end
                                2'd2:
                                begin
                                    cmd.src_a = ett_pkg::SRC_C1P;
                                    cmd.src_b = ett_pkg::SRC_U3;
                                end
                                default:
                                begin
                                    cmd.src_a = ett_pkg::SRC_C1;
                                    cmd.src_b = ett_pkg::SRC_U2;
                                end
                            endcase
                        end
                        default:
                        begin
                            cmd.src_a = ett_pkg::SRC_T;
                            cmd.src_b = ett_pkg::SRC_T;
                        end
                    endcase
                end
            end
            S_MW1:
            begin
                state_next = S_MW2;
            end
            S_MW2:
            begin
                state_next = S_MUSE;
            end
            S_MUSE:
            begin
                if (lerp_reg)
                begin
                    cmd.lerp_store = 1'b1;
                    if (ch_reg == ett_pkg::CH_LAST)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = S_LERP_LOAD;
                    end
                end
                else
                begin
                    // Default: the curve is complete, move on to the channels.
                    ch_next    = ett_pkg::CH_POS_X;
                    state_next = S_LERP_LOAD;
                    case (status.mode)
                        ett_pkg::EASE_OUT_QUAD:
                        begin
                            cmd.op = ett_pkg::DP_E_ONE_MINUS_M;
                        end
                        ett_pkg::EASE_IN_OUT:
                        begin
                            cmd.op = status.t_half ? ett_pkg::DP_E_FROM_M
                                                   : ett_pkg::DP_E_ONE_MINUS_M;
                        end
                        ett_pkg::EASE_OUT_BACK:
                        begin
                            case (jstep_reg)
                                2'd0:
                                begin
                                    cmd.op = ett_pkg::DP_U2_FROM_M;
                                end
                                2'd1:
                                begin
                                    cmd.op = ett_pkg::DP_U3_FROM_M;
                                end
                                2'd2:
                                begin
                                    cmd.op = ett_pkg::DP_ACC_FROM_M;
                                end
                                default:
                                begin
                                    cmd.op = ett_pkg::DP_E_OUTBACK;
                                end
                            endcase
                            if (jstep_reg != 2'd3)
                            begin
                                jstep_next = jstep_reg + 1'b1;
                                state_next = S_MLOAD;
                            end
                        end
                        default:
                        begin
                            cmd.op = ett_pkg::DP_E_FROM_M;
                        end
                    endcase
                end
            end
            S_LERP_LOAD:
            begin
                cmd.op     = ett_pkg::DP_LERP_LOAD;
                lerp_next  = 1'b1;
                state_next = S_MLOAD;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and sequencing registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
            cnt_reg   <= '0;
            jstep_reg <= '0;
            ch_reg    <= '0;
            lerp_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            jstep_reg <= jstep_next;
            ch_reg    <= ch_next;
            lerp_reg  <= lerp_next;
        end
    end

`ifndef SYNTHESIS
    // A result is never shown while a new word could be taken.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("ett_ctrl: result valid while input open");

    // An accepted word is decoded on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DECODE))
        else $error("ett_ctrl: accepted word not decoded");

    // The divider runs exactly FRAC_BITS steps before easing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && cnt_reg == CW'(FRAC_BITS - 1)) |=> (state_reg == S_EASE0))
        else $error("ett_ctrl: divider step count wrong");

    // The channel index stays within the channel list.
    assert property (@(posedge clk) disable iff (!rst_n) ch_reg <= ett_pkg::CH_LAST)
        else $error("ett_ctrl: channel index out of range");
`endif

endmodule

// File: design/ett_dp.sv
// Datapath of the eased transition tween: registers, serial divider, shared multiplier.
// Depends on ett_pkg; sequenced by ett_ctrl.
module ett_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [47:0]         cfg_data,
    input  logic                in_accept,
    input  logic [15:0]         delta_ticks,
    input  ett_pkg::cmd_t       cmd,
    output ett_pkg::status_t    status,
    output logic signed [23:0]  pos_x,
    output logic signed [23:0]  pos_y,
    output logic [15:0]         scale_x,
    output logic [15:0]         scale_y,
    output logic [7:0]          alpha_out,
    output logic                playing,
    output logic                heading_shown
);

    localparam int MW = (FRAC_BITS + 4 > 28) ? FRAC_BITS + 4 : 28;
    localparam int PW = 2 * MW;
    localparam logic signed [MW-1:0] ONE = MW'(64'd1 << FRAC_BITS);
    localparam longint unsigned C1_FULL =
        ((64'd170158 << FRAC_BITS) + 64'd50000) / 64'd100000;
    localparam logic signed [MW-1:0] C1  = MW'(C1_FULL);
    localparam logic signed [MW-1:0] C1P = C1 + ONE;
    localparam logic signed [MW:0] POS_MAX = (MW+1)'(8388607);
    localparam logic signed [MW:0] POS_MIN = (MW+1)'(-8388608);
    localparam logic signed [MW:0] SCL_MAX = (MW+1)'(65535);
    localparam logic signed [MW:0] ALP_MAX = (MW+1)'(255);

    // Configuration registers.
    logic [47:0] htr_reg, str_reg;
    logic [31:0] hsc_reg, ssc_reg;
    logic [7:0]  hal_reg, sal_reg;
    logic [31:0] dur_reg;
    logic [2:0]  mode_reg;

    // Pose state.
    logic [31:0]        elapsed_reg;
    logic               running_reg, dir_reg;
    logic signed [23:0] posx_reg, posy_reg;
    logic [15:0]        sclx_reg, scly_reg;
    logic [7:0]         alpha_reg;

    // Work registers.
    logic [15:0]          delta_reg;
    logic [31:0]          rem_reg;
    logic [FRAC_BITS-1:0] t_reg;
    logic signed [MW-1:0] u_reg, u2_reg, u3_reg, acc_reg, e_reg, from_reg, diff_reg;
    logic signed [MW-1:0] a_reg, b_reg, mres_reg;
    ett_pkg::shift_t      sha_reg, shp_reg;
    logic [PW-1:0]        prod_reg;
    logic                 neg_reg;

    logic [31:0]          dur_eff;
    logic [32:0]          sum_el;
    logic [31:0]          el_sat;
    logic [32:0]          r2;
    logic [32:0]          r2_sub;
    logic                 r2_ge;
    logic signed [MW-1:0] t_ext;
    logic                 pose_shown;
    logic [47:0]          pose_tr;
    logic [31:0]          pose_sc;
    logic [7:0]           pose_al;
    logic [47:0]          ftr, ttr;
    logic [31:0]          fsc, tsc;
    logic [7:0]           fal, tal;
    logic signed [MW-1:0] from_val, to_val;
    logic signed [MW-1:0] a_val, b_val;
    logic [MW-1:0]        a_mag, b_mag;
    logic [5:0]           sh_amt;
    logic [PW:0]          rsum, rshift;
    logic [MW-1:0]        rmag;
    logic signed [MW:0]   lsum;

    assign pos_x         = posx_reg;
    assign pos_y         = posy_reg;
    assign scale_x       = sclx_reg;
    assign scale_y       = scly_reg;
    assign alpha_out     = alpha_reg;
    assign playing       = running_reg;
    assign heading_shown = dir_reg;

    // Elapsed time, completion check and divider step.
    assign dur_eff = (dur_reg == 32'd0) ? 32'd1 : dur_reg;
    assign sum_el  = {1'b0, elapsed_reg} + {17'd0, delta_reg};
    assign el_sat  = sum_el[32] ? 32'hFFFF_FFFF : sum_el[31:0];
    assign r2      = {rem_reg, 1'b0};
    assign r2_ge   = (r2 >= {1'b0, dur_eff});
    assign r2_sub  = r2 - {1'b0, dur_eff};
    assign t_ext   = MW'({1'b0, t_reg});

    assign status.running = running_reg;
    assign status.done    = (elapsed_reg >= dur_eff);
    assign status.t_half  = ~t_reg[FRAC_BITS-1];
    assign status.mode    = mode_reg;

    // End pose selection for play, jump and finish.
    always_comb
    begin
        case (cmd.op)
            ett_pkg::DP_PLAY:
            begin
                pose_shown = (dur_reg != 32'd0) ? ~cmd.dir : cmd.dir;
            end
            ett_pkg::DP_JUMP:
            begin
                pose_shown = cmd.dir;
            end
            default:
            begin
                pose_shown = dir_reg;
            end
        endcase
    end

    assign pose_tr = pose_shown ? str_reg : htr_reg;
    assign pose_sc = pose_shown ? ssc_reg : hsc_reg;
    assign pose_al = pose_shown ? sal_reg : hal_reg;

    // Start and end values of the channel being interpolated.
    assign ftr = dir_reg ? htr_reg : str_reg;
    assign ttr = dir_reg ? str_reg : htr_reg;
    assign fsc = dir_reg ? hsc_reg : ssc_reg;
    assign tsc = dir_reg ? ssc_reg : hsc_reg;
    assign fal = dir_reg ? hal_reg : sal_reg;
    assign tal = dir_reg ? sal_reg : hal_reg;

    always_comb
    begin
        case (cmd.ch)
            ett_pkg::CH_POS_X:
            begin
                from_val = MW'(signed'(ftr[23:0]));
                to_val   = MW'(signed'(ttr[23:0]));
            end
            ett_pkg::CH_POS_Y:
            begin
                from_val = MW'(signed'(ftr[47:24]));
                to_val   = MW'(signed'(ttr[47:24]));
            end
            ett_pkg::CH_SCALE_X:
            begin
                from_val = MW'({1'b0, fsc[15:0]});
                to_val   = MW'({1'b0, tsc[15:0]});
            end
            ett_pkg::CH_SCALE_Y:
            begin
                from_val = MW'({1'b0, fsc[31:16]});
                to_val   = MW'({1'b0, tsc[31:16]});
            end
            default:
            begin
                from_val = MW'({1'b0, fal});
                to_val   = MW'({1'b0, tal});
            end
        endcase
    end

    // Multiplier operand selection.
    always_comb
    begin
        case (cmd.src_a)
            ett_pkg::SRC_T:    a_val = t_ext;
            ett_pkg::SRC_U:    a_val = u_reg;
            ett_pkg::SRC_U2:   a_val = u2_reg;
            ett_pkg::SRC_U3:   a_val = u3_reg;
            ett_pkg::SRC_C1:   a_val = C1;
            ett_pkg::SRC_C1P:  a_val = C1P;
            ett_pkg::SRC_DIFF: a_val = diff_reg;
            default:           a_val = e_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.src_b)
            ett_pkg::SRC_T:    b_val = t_ext;
            ett_pkg::SRC_U:    b_val = u_reg;
            ett_pkg::SRC_U2:   b_val = u2_reg;
            ett_pkg::SRC_U3:   b_val = u3_reg;
            ett_pkg::SRC_C1:   b_val = C1;
            ett_pkg::SRC_C1P:  b_val = C1P;
            ett_pkg::SRC_DIFF: b_val = diff_reg;
            default:           b_val = e_reg;
        endcase
    end

    // Sign-magnitude product, then rounding half away from zero.
    assign a_mag = a_reg[MW-1] ? MW'(-a_reg) : MW'(a_reg);
    assign b_mag = b_reg[MW-1] ? MW'(-b_reg) : MW'(b_reg);

    always_comb
    begin
        case (shp_reg)
            ett_pkg::SH_FM1: sh_amt = 6'(FRAC_BITS - 1);
            ett_pkg::SH_FP1: sh_amt = 6'(FRAC_BITS + 1);
            default:         sh_amt = 6'(FRAC_BITS);
        endcase
    end

    assign rsum   = {1'b0, prod_reg} + ((PW+1)'(1) << (sh_amt - 6'd1));
    assign rshift = rsum >> sh_amt;
    assign rmag   = rshift[MW-1:0];
    assign lsum   = (MW+1)'(from_reg) + (MW+1)'(mres_reg);

    // Configuration and pose state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            htr_reg     <= '0;
            hsc_reg     <= ett_pkg::SCALE_RESET;
            hal_reg     <= '0;
            str_reg     <= '0;
            ssc_reg     <= ett_pkg::SCALE_RESET;
            sal_reg     <= ett_pkg::SHOWN_ALPHA_RESET;
            dur_reg     <= '0;
            mode_reg    <= ett_pkg::EASE_LINEAR;
            elapsed_reg <= '0;
            running_reg <= 1'b0;
            dir_reg     <= 1'b0;
            posx_reg    <= '0;
            posy_reg    <= '0;
            sclx_reg    <= '0;
            scly_reg    <= '0;
            alpha_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    ett_pkg::REG_HIDDEN_TR:    htr_reg  <= cfg_data;
                    ett_pkg::REG_HIDDEN_SCALE: hsc_reg  <= cfg_data[31:0];
                    ett_pkg::REG_HIDDEN_ALPHA: hal_reg  <= cfg_data[7:0];
                    ett_pkg::REG_SHOWN_TR:     str_reg  <= cfg_data;
                    ett_pkg::REG_SHOWN_SCALE:  ssc_reg  <= cfg_data[31:0];
                    ett_pkg::REG_SHOWN_ALPHA:  sal_reg  <= cfg_data[7:0];
                    ett_pkg::REG_DURATION:     dur_reg  <= cfg_data[31:0];
                    default:                   mode_reg <= cfg_data[2:0];
                endcase
            end
            case (cmd.op)
                ett_pkg::DP_ELAPSED:
                begin
                    elapsed_reg <= el_sat;
                end
                ett_pkg::DP_PLAY, ett_pkg::DP_JUMP, ett_pkg::DP_FINISH:
                begin
                    if (cmd.op != ett_pkg::DP_FINISH)
                    begin
                        dir_reg     <= cmd.dir;
                        elapsed_reg <= '0;
                    end
                    running_reg <= (cmd.op == ett_pkg::DP_PLAY) && (dur_reg != 32'd0);
                    posx_reg    <= pose_tr[23:0];
                    posy_reg    <= pose_tr[47:24];
                    sclx_reg    <= pose_sc[15:0];
                    scly_reg    <= pose_sc[31:16];
                    alpha_reg   <= pose_al;
                end
                default:
                begin
                end
            endcase
            // Saturated write-back of one interpolated channel.
            if (cmd.lerp_store)
            begin
                case (cmd.ch)
                    ett_pkg::CH_POS_X, ett_pkg::CH_POS_Y:
                    begin
                        if (cmd.ch == ett_pkg::CH_POS_X)
                        begin
                            posx_reg <= (lsum > POS_MAX) ? 24'h7F_FFFF :
                                        (lsum < POS_MIN) ? 24'h80_0000 : lsum[23:0];
                        end
                        else
                        begin
                            posy_reg <= (lsum > POS_MAX) ? 24'h7F_FFFF :
                                        (lsum < POS_MIN) ? 24'h80_0000 : lsum[23:0];
                        end
                    end
                    ett_pkg::CH_SCALE_X:
                    begin
                        sclx_reg <= lsum[MW] ? 16'd0 :
                                    (lsum > SCL_MAX) ? 16'hFFFF : lsum[15:0];
                    end
                    ett_pkg::CH_SCALE_Y:
                    begin
                        scly_reg <= lsum[MW] ? 16'd0 :
                                    (lsum > SCL_MAX) ? 16'hFFFF : lsum[15:0];
                    end
                    default:
                    begin
                        alpha_reg <= lsum[MW] ? 8'd0 :
                                     (lsum > ALP_MAX) ? 8'hFF : lsum[7:0];
                    end
                endcase
            end
        end
    end

    // Divider, easing and multiplier work registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            delta_reg <= delta_ticks;
        end
        case (cmd.op)
            ett_pkg::DP_DIV_INIT:
            begin
                rem_reg <= elapsed_reg;
                t_reg   <= '0;
            end
            ett_pkg::DP_DIV_STEP:
            begin
                rem_reg <= r2_ge ? r2_sub[31:0] : r2[31:0];
                t_reg   <= {t_reg[FRAC_BITS-2:0], r2_ge};
            end
            ett_pkg::DP_SETU:
            begin
                case (mode_reg)
                    ett_pkg::EASE_IN_OUT:   u_reg <= (ONE <<< 1) - (t_ext <<< 1);
                    ett_pkg::EASE_OUT_BACK: u_reg <= t_ext - ONE;
                    default:                u_reg <= ONE - t_ext;
                endcase
            end
            ett_pkg::DP_E_FROM_T:      e_reg   <= t_ext;
            ett_pkg::DP_E_FROM_M:      e_reg   <= mres_reg;
            ett_pkg::DP_E_ONE_MINUS_M: e_reg   <= ONE - mres_reg;
            ett_pkg::DP_U2_FROM_M:     u2_reg  <= mres_reg;
            ett_pkg::DP_U3_FROM_M:     u3_reg  <= mres_reg;
            ett_pkg::DP_ACC_FROM_M:    acc_reg <= mres_reg;
            ett_pkg::DP_E_OUTBACK:     e_reg   <= ONE + acc_reg + mres_reg;
            ett_pkg::DP_LERP_LOAD:
            begin
                from_reg <= from_val;
                diff_reg <= to_val - from_val;
            end
            default:
            begin
            end
        endcase
        if (cmd.mul_load)
        begin
            a_reg   <= a_val;
            b_reg   <= b_val;
            sha_reg <= cmd.shift;
        end
        prod_reg <= PW'(a_mag) * PW'(b_mag);
        neg_reg  <= a_reg[MW-1] ^ b_reg[MW-1];
        shp_reg  <= sha_reg;
        mres_reg <= neg_reg ? -signed'(rmag) : signed'(rmag);
    end

endmodule
